### design/rpi_pkg.sv
// Shared types and constants for the ray/plane intersection block.
// Holds the number format, field widths, payload structs and codes.
// No dependencies.
package rpi_pkg;

  // Fixed point format
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int DIST_W     = 31;
  localparam int RGB_W      = 24;
  localparam int EPS_W      = 16;
  localparam int CAUSE_W    = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int DIFF_W   = COORD_W + 1;          // anchor - origin
  localparam int PROD_A_W = 2 * COORD_W;          // normal * direction
  localparam int PROD_N_W = COORD_W + DIFF_W;     // normal * (anchor - origin)
  localparam int ANG_W    = PROD_A_W + 2;         // sum of three
  localparam int NUM_W    = PROD_N_W + 2;
  localparam int AMAG_W   = ANG_W - 1;
  localparam int NMAG_W   = NUM_W - 1;
  localparam int REM_W    = NMAG_W + FRAC_BITS;   // dividend, numerator scaled
  localparam int CMP_W    = AMAG_W + DIST_W;      // divisor at its largest shift
  localparam int HPROD_W  = COORD_W + DIST_W + 1; // direction * distance

  localparam logic [DIST_W-1:0]  DIST_MAX = {DIST_W{1'b1}};
  localparam logic [COORD_W-1:0] ONE_FX   = COORD_W'(1) << FRAC_BITS;

  // Queues
  localparam int FRONT_DEPTH = 8;
  localparam int FRONT_PTR_W = $clog2(FRONT_DEPTH);
  localparam int FRONT_CNT_W = $clog2(FRONT_DEPTH + 1);
  localparam int OUT_DEPTH   = 64;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NORMAL_X = 4'd0,
    REG_NORMAL_Y = 4'd1,
    REG_NORMAL_Z = 4'd2,
    REG_ANCHOR_X = 4'd3,
    REG_ANCHOR_Y = 4'd4,
    REG_ANCHOR_Z = 4'd5,
    REG_PLANE_RGB = 4'd6,
    REG_EPS      = 4'd7
  } cfg_reg_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_HIT      = 2'd0,
    CAUSE_PARALLEL = 2'd1,
    CAUSE_BEHIND   = 2'd2
  } cause_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic                      hit;
    logic [CAUSE_W-1:0]        miss_cause;
    logic [DIST_W-1:0]         hit_distance;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
    logic [RGB_W-1:0]          hit_rgb;
  } ray_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] normal_x;
    logic signed [COORD_W-1:0] normal_y;
    logic signed [COORD_W-1:0] normal_z;
    logic signed [COORD_W-1:0] anchor_x;
    logic signed [COORD_W-1:0] anchor_y;
    logic signed [COORD_W-1:0] anchor_z;
    logic [RGB_W-1:0]          plane_rgb;
    logic [EPS_W-1:0]          eps_threshold;
  } plane_cfg_t;

  // Classified ray handed from front to back
  typedef struct packed {
    cause_t            cause;
    logic [AMAG_W-1:0] amag;
    logic [NMAG_W-1:0] nmag;
    ray_in_t           ray;
  } ray_job_t;

endpackage

### design/ray_plane_intersect.sv
// Top level of the ray/plane intersection block: configuration registers,
// credit control and the front, queue, back and result buffer. Uses rpi_pkg.
//
// Each ray transfer produces exactly one result transfer, in order. A new ray
// is taken every cycle while full is low; each ray passes through 3 front
// stages, the job queue, one entry register, 31 divider stages plus an
// overflow stage, the hit-point multiply and the result buffer's memory and
// output register. The divider yields one quotient bit per stage. Flow control
// is credit based: full rises when 8 rays sit between input and the back end,
// and the back end draws from the job queue only while fewer than 64 results
// are in flight or buffered, so nothing stalls mid-pipe and a slow consumer
// costs no results. Configuration writes take effect at once and must be made
// only with the block empty of work.
module ray_plane_intersect (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  rpi_pkg::ray_in_t                    in_item,
  output logic                                empty,
  input  logic                                pop,
  output rpi_pkg::ray_out_t                   out_item,
  input  logic                                cfg_we,
  input  logic [rpi_pkg::CFG_ADDR_W-1:0]      cfg_index,
  input  logic [rpi_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rpi_pkg::*;

  plane_cfg_t              cfg_r, cfg_nxt;
  logic [FRONT_CNT_W-1:0]  front_cnt_r, front_cnt_nxt;
  logic [OUT_CNT_W-1:0]    back_cnt_r, back_cnt_nxt;
  logic                    in_acc, out_acc, q_pop, q_empty;
  logic                    job_valid, res_valid;
  ray_job_t                front_job, head_job;
  ray_out_t                res;

  // Configuration write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_NORMAL_X:  cfg_nxt.normal_x      = cfg_data[COORD_W-1:0];
        REG_NORMAL_Y:  cfg_nxt.normal_y      = cfg_data[COORD_W-1:0];
        REG_NORMAL_Z:  cfg_nxt.normal_z      = cfg_data[COORD_W-1:0];
        REG_ANCHOR_X:  cfg_nxt.anchor_x      = cfg_data[COORD_W-1:0];
        REG_ANCHOR_Y:  cfg_nxt.anchor_y      = cfg_data[COORD_W-1:0];
        REG_ANCHOR_Z:  cfg_nxt.anchor_z      = cfg_data[COORD_W-1:0];
        REG_PLANE_RGB: cfg_nxt.plane_rgb     = cfg_data[RGB_W-1:0];
        REG_EPS:       cfg_nxt.eps_threshold = cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_x      <= '0;
      cfg_r.normal_y      <= ONE_FX;
      cfg_r.normal_z      <= '0;
      cfg_r.anchor_x      <= '0;
      cfg_r.anchor_y      <= '0;
      cfg_r.anchor_z      <= '0;
      cfg_r.plane_rgb     <= {RGB_W{1'b1}};
      cfg_r.eps_threshold <= EPS_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Credits: front counts rays not yet drawn from the job queue, back counts
  // jobs drawn but whose result transfer has not happened
  always_comb begin
    in_acc        = push && !full;
    out_acc       = pop && !empty;
    q_pop         = !q_empty && (back_cnt_r < OUT_CNT_W'(OUT_DEPTH));
    front_cnt_nxt = front_cnt_r + FRONT_CNT_W'(in_acc) - FRONT_CNT_W'(q_pop);
    back_cnt_nxt  = back_cnt_r + OUT_CNT_W'(q_pop) - OUT_CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_cnt_r <= '0;
      back_cnt_r  <= '0;
    end else begin
      front_cnt_r <= front_cnt_nxt;
      back_cnt_r  <= back_cnt_nxt;
    end
  end

  assign full = (front_cnt_r == FRONT_CNT_W'(FRONT_DEPTH));

  rpi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_acc),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job       (front_job)
  );

  rpi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (front_job),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  rpi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_pop),
    .job       (head_job),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  rpi_out_fifo u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_item (res),
    .pop     (pop),
    .empty   (empty),
    .rd_item (out_item)
  );

  a_front_credit: assert property (@(posedge clk) disable iff (!rst_n)
    front_cnt_r <= FRONT_CNT_W'(FRONT_DEPTH))
    else $error("front credit count out of range");
  a_back_credit: assert property (@(posedge clk) disable iff (!rst_n)
    back_cnt_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("back credit count out of range");
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.hit) |->
      (out_item.hit_distance == '0 && out_item.hit_rgb == '0 &&
       out_item.miss_cause != CAUSE_HIT))
    else $error("miss result carries hit data");

endmodule

### design/rpi_front.sv
// Front end: dot products of the plane normal and parallel/behind classification.
// Three register stages, no stall; depends on rpi_pkg.
module rpi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  rpi_pkg::ray_in_t    in_item,
  input  rpi_pkg::plane_cfg_t cfg,
  output logic                job_valid,
  output rpi_pkg::ray_job_t   job
);
  import rpi_pkg::*;

  logic signed [COORD_W-1:0]  org [3];
  logic signed [COORD_W-1:0]  dir [3];
  logic signed [COORD_W-1:0]  nrm [3];
  logic signed [COORD_W-1:0]  anc [3];

  logic                       s1_v_r, s2_v_r, s3_v_r;
  ray_in_t                    ray1_r, ray2_r, ray3_r;
  logic signed [COORD_W-1:0]  d1_r    [3];
  logic signed [DIFF_W-1:0]   diff1_r [3];
  logic signed [PROD_A_W-1:0] pa2_r   [3];
  logic signed [PROD_N_W-1:0] pn2_r   [3];
  logic signed [ANG_W-1:0]    ang3_r;
  logic signed [NUM_W-1:0]    num3_r;

  logic                       ang_neg, num_neg, parallel, behind;
  logic [ANG_W-1:0]           ang_abs;
  logic [NUM_W-1:0]           num_abs;
  logic [AMAG_W-1:0]          eps_w;

  always_comb begin
    org[0] = in_item.origin_x;  org[1] = in_item.origin_y;  org[2] = in_item.origin_z;
    dir[0] = in_item.dir_x;     dir[1] = in_item.dir_y;     dir[2] = in_item.dir_z;
    nrm[0] = cfg.normal_x;      nrm[1] = cfg.normal_y;      nrm[2] = cfg.normal_z;
    anc[0] = cfg.anchor_x;      anc[1] = cfg.anchor_y;      anc[2] = cfg.anchor_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Stage 1: anchor - origin
  always_ff @(posedge clk) begin
    ray1_r <= in_item;
    for (int i = 0; i < 3; i++) begin
      d1_r[i]    <= dir[i];
      diff1_r[i] <= {anc[i][COORD_W-1], anc[i]} - {org[i][COORD_W-1], org[i]};
    end
  end

  // Stage 2: six products
  always_ff @(posedge clk) begin
    ray2_r <= ray1_r;
    for (int i = 0; i < 3; i++) begin
      pa2_r[i] <= nrm[i] * d1_r[i];
      pn2_r[i] <= nrm[i] * diff1_r[i];
    end
  end

  // Stage 3: sums
  always_ff @(posedge clk) begin
    ray3_r <= ray2_r;
    ang3_r <= ANG_W'(pa2_r[0]) + ANG_W'(pa2_r[1]) + ANG_W'(pa2_r[2]);
    num3_r <= NUM_W'(pn2_r[0]) + NUM_W'(pn2_r[1]) + NUM_W'(pn2_r[2]);
  end

  // Classification
  always_comb begin
    ang_neg  = ang3_r[ANG_W-1];
    num_neg  = num3_r[NUM_W-1];
    ang_abs  = ang_neg ? ANG_W'(-ang3_r) : ANG_W'(ang3_r);
    num_abs  = num_neg ? NUM_W'(-num3_r) : NUM_W'(num3_r);
    eps_w    = AMAG_W'(cfg.eps_threshold) << FRAC_BITS;
    parallel = (ang3_r == '0) || (ang_abs[AMAG_W-1:0] < eps_w);
    behind   = (num3_r != '0) && (num_neg != ang_neg);

    job.amag = ang_abs[AMAG_W-1:0];
    job.nmag = num_abs[NMAG_W-1:0];
    job.ray  = ray3_r;
    priority if (parallel) job.cause = CAUSE_PARALLEL;
    else if (behind)       job.cause = CAUSE_BEHIND;
    else                   job.cause = CAUSE_HIT;
  end

  assign job_valid = s3_v_r;

endmodule

### design/rpi_queue.sv
// Short job queue between front and back ends.
// Register array with one read port; depends on rpi_pkg.
module rpi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rpi_pkg::ray_job_t push_job,
  input  logic              pop,
  output logic              empty,
  output rpi_pkg::ray_job_t head_job
);
  import rpi_pkg::*;

  ray_job_t                 mem_r [FRONT_DEPTH];
  logic [FRONT_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FRONT_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FRONT_CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + FRONT_CNT_W'(push) - FRONT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  assign empty    = (cnt_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < FRONT_CNT_W'(FRONT_DEPTH)) || pop)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue underflow");

endmodule

### design/rpi_back.sv
// Back end: pipelined restoring divider for the distance, then hit point.
// One bit of quotient per stage, no stall; depends on rpi_pkg.
module rpi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  rpi_pkg::ray_job_t   job,
  input  rpi_pkg::plane_cfg_t cfg,
  output logic                res_valid,
  output rpi_pkg::ray_out_t   res
);
  import rpi_pkg::*;

  typedef struct packed {
    cause_t            cause;
    logic              ovf;
    logic [DIST_W-1:0] quo;
    logic [REM_W-1:0]  rem;
    logic [AMAG_W-1:0] amag;
    ray_in_t           ray;
  } div_stage_t;

  logic                       job_v_r;
  ray_job_t                   job_r;
  logic [DIST_W:0]            div_v_r;
  div_stage_t                 divs_r   [DIST_W+1];
  div_stage_t                 divs_nxt [DIST_W];
  logic [REM_W-1:0]           dividend;
  logic                       ovf;
  logic [CMP_W-1:0]           shd   [DIST_W];
  logic [CMP_W-1:0]           diffv [DIST_W];
  logic                       ge    [DIST_W];

  div_stage_t                 fin;
  logic [DIST_W-1:0]          t_val;
  logic                       near, hit_m;
  cause_t                     cause_m;
  logic signed [COORD_W-1:0]  dvec [3];
  logic signed [COORD_W-1:0]  ovec [3];

  logic                       mul_v_r;
  logic                       mul_hit_r;
  cause_t                     mul_cause_r;
  logic [DIST_W-1:0]          mul_t_r;
  logic signed [COORD_W-1:0]  mul_o_r [3];
  logic signed [HPROD_W-1:0]  mul_p_r [3];
  logic signed [HPROD_W-1:0]  csum    [3];
  logic signed [COORD_W-1:0]  csat    [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      div_v_r <= '0;
      mul_v_r <= 1'b0;
    end else begin
      job_v_r <= job_valid;
      div_v_r <= {div_v_r[DIST_W-1:0], job_v_r};
      mul_v_r <= div_v_r[DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job;
  end

  // Quotient overflows the distance field when dividend >= divisor << DIST_W
  always_comb begin
    dividend = {job_r.nmag, {FRAC_BITS{1'b0}}};
    ovf      = CMP_W'(dividend) >= (CMP_W'(job_r.amag) << DIST_W);
  end

  always_comb begin
    for (int j = 0; j < DIST_W; j++) begin
      shd[j]      = CMP_W'(divs_r[j].amag) << (DIST_W - 1 - j);
      ge[j]       = CMP_W'(divs_r[j].rem) >= shd[j];
      diffv[j]    = CMP_W'(divs_r[j].rem) - shd[j];
      divs_nxt[j] = divs_r[j];
      if (ge[j]) begin
        divs_nxt[j].rem             = diffv[j][REM_W-1:0];
        divs_nxt[j].quo[DIST_W-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    divs_r[0].cause <= job_r.cause;
    divs_r[0].ovf   <= ovf;
    divs_r[0].quo   <= '0;
    divs_r[0].rem   <= dividend;
    divs_r[0].amag  <= job_r.amag;
    divs_r[0].ray   <= job_r.ray;
    for (int j = 0; j < DIST_W; j++) begin
      divs_r[j+1] <= divs_nxt[j];
    end
  end

  // Distance, late behind test, then direction * distance
  always_comb begin
    fin     = divs_r[DIST_W];
    t_val   = fin.ovf ? DIST_MAX : fin.quo;
    near    = !fin.ovf && (fin.quo < DIST_W'(cfg.eps_threshold));
    hit_m   = (fin.cause == CAUSE_HIT) && !near;
    cause_m = (fin.cause == CAUSE_HIT && near) ? CAUSE_BEHIND : fin.cause;
    dvec[0] = fin.ray.dir_x;    dvec[1] = fin.ray.dir_y;    dvec[2] = fin.ray.dir_z;
    ovec[0] = fin.ray.origin_x; ovec[1] = fin.ray.origin_y; ovec[2] = fin.ray.origin_z;
  end

  always_ff @(posedge clk) begin
    mul_hit_r   <= hit_m;
    mul_cause_r <= cause_m;
    mul_t_r     <= t_val;
    for (int i = 0; i < 3; i++) begin
      mul_o_r[i] <= ovec[i];
      mul_p_r[i] <= dvec[i] * $signed({1'b0, t_val});
    end
  end

  // origin + floor(product / 2^FRAC_BITS), saturated to the coordinate range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = HPROD_W'(mul_o_r[i]) + (mul_p_r[i] >>> FRAC_BITS);
      if (csum[i][HPROD_W-1:COORD_W-1] == '0 || csum[i][HPROD_W-1:COORD_W-1] == '1)
        csat[i] = csum[i][COORD_W-1:0];
      else if (csum[i][HPROD_W-1])
        csat[i] = {1'b1, {(COORD_W-1){1'b0}}};
      else
        csat[i] = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_comb begin
    res            = '0;
    res.miss_cause = mul_cause_r;
    if (mul_hit_r) begin
      res.hit          = 1'b1;
      res.hit_distance = mul_t_r;
      res.hit_x        = csat[0];
      res.hit_y        = csat[1];
      res.hit_z        = csat[2];
      res.hit_rgb      = cfg.plane_rgb;
    end
  end

  assign res_valid = mul_v_r;

endmodule

### design/rpi_out_fifo.sv
// Result buffer: memory FIFO with a registered read into the output register.
// Depends on rpi_pkg.
module rpi_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  rpi_pkg::ray_out_t wr_item,
  input  logic              pop,
  output logic              empty,
  output rpi_pkg::ray_out_t rd_item
);
  import rpi_pkg::*;

  ray_out_t               mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   out_v_r, out_v_nxt;
  ray_out_t               out_r;
  logic                   pop_acc, ld;

  always_comb begin
    pop_acc    = pop && out_v_r;
    ld         = (cnt_r != '0) && (!out_v_r || pop_acc);
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = ld ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + OUT_CNT_W'(wr_en) - OUT_CNT_W'(ld);
    priority if (ld) out_v_nxt = 1'b1;
    else if (pop_acc) out_v_nxt = 1'b0;
    else              out_v_nxt = out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (ld) out_r <= mem[rd_ptr_r];
  end

  assign empty   = !out_v_r;
  assign rd_item = out_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> cnt_r < OUT_CNT_W'(OUT_DEPTH))
    else $error("result buffer overflow");

endmodule

### bench/tb_top.sv
// Self-checking bench for ray_plane_intersect: rays against a configured plane.
// Needs rpi_pkg and the ray_plane_intersect top level, nothing else.
module tb_top;
  import rpi_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  ray_in_t    in_item;
  logic       empty;
  logic       pop;
  ray_out_t   out_item;
  logic       cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ray_plane_intersect dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 60;

  // bench copy of the plane registers
  plane_cfg_t plane;

  ray_in_t  ray_backlog[$];   // rays not yet offered to the block
  ray_out_t answers_due[$];   // predicted results, oldest first

  int idle_pct;
  int stall_pct;
  int hold_ticket;
  int hold_seen;
  int hold_cnt;
  logic in_took;
  int errors;
  int quiet_cycles;
  int n_rays, n_hits, n_parallel, n_behind;

  // clock: period 4
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Predictor: wide signed arithmetic so nothing overflows before saturation
  // -------------------------------------------------------------------------
  function automatic ray_out_t trace_plane(ray_in_t r);
    ray_out_t res;
    logic signed [127:0] o[3], d[3], nv[3], pv[3];
    logic signed [127:0] ang, num, prod, c;
    logic [127:0] amag, nmag, epsw, q;
    logic [DIST_W-1:0] t;
    o[0] = r.origin_x;  o[1] = r.origin_y;  o[2] = r.origin_z;
    d[0] = r.dir_x;     d[1] = r.dir_y;     d[2] = r.dir_z;
    nv[0] = plane.normal_x; nv[1] = plane.normal_y; nv[2] = plane.normal_z;
    pv[0] = plane.anchor_x; pv[1] = plane.anchor_y; pv[2] = plane.anchor_z;
    res = '0;
    ang = 0;
    num = 0;
    for (int i = 0; i < 3; i++) begin
      ang = ang + nv[i] * d[i];
      num = num + nv[i] * (pv[i] - o[i]);
    end
    amag = (ang < 0) ? -ang : ang;
    nmag = (num < 0) ? -num : num;
    epsw = 128'(plane.eps_threshold) << FRAC_BITS;
    if (ang == 0 || amag < epsw) begin
      res.miss_cause = CAUSE_PARALLEL;
      return res;
    end
    // numerator of opposite sign: plane behind the origin
    if (num != 0 && ((num < 0) != (ang < 0))) begin
      res.miss_cause = CAUSE_BEHIND;
      return res;
    end
    q = (nmag << FRAC_BITS) / amag;
    if (q < 128'(plane.eps_threshold)) begin
      res.miss_cause = CAUSE_BEHIND;
      return res;
    end
    t = (q > 128'(DIST_MAX)) ? DIST_MAX : q[DIST_W-1:0];
    res.hit = 1'b1;
    res.miss_cause = CAUSE_HIT;
    res.hit_distance = t;
    for (int i = 0; i < 3; i++) begin
      prod = d[i] * $signed({97'b0, t});
      c = o[i] + (prod >>> FRAC_BITS);  // floor shift
      if (c > 128'sh7FFF_FFFF) c = 128'sh7FFF_FFFF;
      if (c < -128'sh8000_0000) c = -128'sh8000_0000;
      case (i)
        0: res.hit_x = c[31:0];
        1: res.hit_y = c[31:0];
        default: res.hit_z = c[31:0];
      endcase
    end
    res.hit_rgb = plane.plane_rgb;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Ray driver: changes at the falling edge, holds an offer until transferred
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_item <= '0;
    end else if (!push || in_took) begin
      if (ray_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= ray_backlog.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus the long hold when one is requested
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_cnt <= LONG_HOLD;
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: samples both transfers at the rising edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    ray_out_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= push && !full;
      if (push && !full) begin
        answers_due.insert(answers_due.size(), trace_plane(in_item));
        n_rays++;
      end
      if (pop && !empty) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, out_item);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (out_item !== want) begin
            $display("%0t: mismatch expected hit=%b cause=%0d t=%h xyz=%h %h %h rgb=%h",
                     $time, want.hit, want.miss_cause, want.hit_distance,
                     want.hit_x, want.hit_y, want.hit_z, want.hit_rgb);
            $display("%0t:          actual hit=%b cause=%0d t=%h xyz=%h %h %h rgb=%h",
                     $time, out_item.hit, out_item.miss_cause, out_item.hit_distance,
                     out_item.hit_x, out_item.hit_y, out_item.hit_z, out_item.hit_rgb);
            errors++;
          end
          if (want.hit) n_hits++;
          else if (want.miss_cause == CAUSE_PARALLEL) n_parallel++;
          else n_behind++;
        end
      end
    end
  end

  // Watchdog: cycles with work outstanding but no transfer on either side
  always @(posedge clk) begin
    if (rst_n && (ray_backlog.size() > 0 || push || answers_due.size() > 0)
        && !(push && !full) && !(pop && !empty)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding",
                 $time, answers_due.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    // indexes beyond the list are ignored by the block
    case (idx)
      REG_NORMAL_X:  plane.normal_x = val;
      REG_NORMAL_Y:  plane.normal_y = val;
      REG_NORMAL_Z:  plane.normal_z = val;
      REG_ANCHOR_X:  plane.anchor_x = val;
      REG_ANCHOR_Y:  plane.anchor_y = val;
      REG_ANCHOR_Z:  plane.anchor_z = val;
      REG_PLANE_RGB: plane.plane_rgb = val[RGB_W-1:0];
      REG_EPS:       plane.eps_threshold = val[EPS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_plane(input logic [31:0] nx, ny, nz, ax, ay, az, rgb, eps);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_ANCHOR_X, ax);
    write_reg(REG_ANCHOR_Y, ay);
    write_reg(REG_ANCHOR_Z, az);
    write_reg(REG_PLANE_RGB, rgb);
    write_reg(REG_EPS, eps);
  endtask

  // value in +/- span units of 1.0, random fraction
  function automatic logic [31:0] near_val(input int span);
    return $urandom_range(0, (2 * span) << FRAC_BITS) - (span << FRAC_BITS);
  endfunction

  function automatic logic [31:0] edge_val();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  function automatic ray_in_t pick_ray();
    ray_in_t r;
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      r.origin_x = near_val(20); r.origin_y = near_val(20); r.origin_z = near_val(20);
      r.dir_x = near_val(2);     r.dir_y = near_val(2);     r.dir_z = near_val(2);
    end else if (kind < 85) begin
      r.origin_x = $urandom; r.origin_y = $urandom; r.origin_z = $urandom;
      r.dir_x = $urandom;    r.dir_y = $urandom;    r.dir_z = $urandom;
    end else begin
      r.origin_x = edge_val(); r.origin_y = edge_val(); r.origin_z = edge_val();
      r.dir_x = edge_val();    r.dir_y = edge_val();    r.dir_z = edge_val();
    end
    return r;
  endfunction

  function automatic ray_in_t mk_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
    ray_in_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx;    r.dir_y = dy;    r.dir_z = dz;
    return r;
  endfunction

  // append a ray to the backlog
  task automatic queue_ray(input ray_in_t r);
    ray_backlog.insert(ray_backlog.size(), r);
  endtask

  // all rays offered and every result back
  task automatic settle();
    while (ray_backlog.size() > 0 || push || answers_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int idle, input int stall,
                           input bit long_hold);
    idle_pct = idle;
    stall_pct = stall;
    if (long_hold) hold_ticket++;
    for (int i = 0; i < count; i++) queue_ray(pick_ray());
    settle();
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_ticket = 0;
    errors = 0;
    quiet_cycles = 0;
    n_rays = 0; n_hits = 0; n_parallel = 0; n_behind = 0;
    // reset values: plane y = 0, normal +y, white, epsilon one lsb
    plane = '0;
    plane.normal_y = 32'h0001_0000;
    plane.plane_rgb = 24'hFFFFFF;
    plane.eps_threshold = 16'd1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rays against the reset plane
    queue_ray(mk_ray(0, 32'h000A_0000, 0, 0, 32'hFFFF_0000, 0)); // plain hit
    queue_ray(mk_ray(0, 32'h000A_0000, 0, 32'h0001_0000, 0, 0)); // parallel
    queue_ray(mk_ray(0, 32'h000A_0000, 0, 0, 32'h0001_0000, 0)); // behind
    queue_ray(mk_ray(5, 0, 7, 0, 32'hFFFF_0000, 0));             // t of zero
    // tiny angle, far origin: distance and hit point saturate both ways
    queue_ray(mk_ray(0, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
    queue_ray(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    queue_ray(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    queue_ray(mk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    queue_ray(mk_ray(0, 32'h0000_8000, 0, 0, 32'hFFFF_FFFF, 0)); // angle just at eps: not parallel
    settle();

    // epsilon zero: origin on the plane hits at t = 0, zero angle still parallel
    write_reg(REG_EPS, 32'h0);
    write_reg(4'd8, 32'hDEAD_BEEF);   // out of range, ignored
    write_reg(4'd15, 32'h1234_5678);  // out of range, ignored
    queue_ray(mk_ray(3, 0, 9, 32'h0001_0000, 32'hFFFF_0000, 0));
    queue_ray(mk_ray(3, 32'h0001_0000, 9, 32'h0001_0000, 0, 0));
    queue_ray(mk_ray(0, 32'h0000_0001, 0, 0, 32'hFFFF_FFFF, 0));
    queue_ray(mk_ray(0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF));
    settle();

    // random phases; each idling mode, several plane settings
    load_plane(near_val(2), near_val(2), near_val(2), near_val(20), near_val(20),
               near_val(20), $urandom, $urandom_range(0, 300));
    run_phase(90, 0, 0, 1'b1);   // receiver holds off while rays keep coming
    load_plane(near_val(2), near_val(2), near_val(2), near_val(20), near_val(20),
               near_val(20), 32'h0, 32'hFFFF);  // largest epsilon, black
    run_phase(70, 63, 0, 1'b0);
    load_plane(near_val(2), near_val(2), near_val(2), near_val(20), near_val(20),
               near_val(20), 32'hFF_FFFF, 32'h0);
    run_phase(90, 0, 63, 1'b0);
    load_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, $urandom, $urandom_range(0, 65535));
    run_phase(60, 20, 20, 1'b0);
    load_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
    run_phase(60, 0, 0, 1'b0);
    load_plane(near_val(1), near_val(1), near_val(1), near_val(5), near_val(5),
               near_val(5), $urandom, $urandom_range(0, 20));
    run_phase(90, 20, 20, 1'b1);
    load_plane(near_val(2), 0, near_val(2), near_val(20), near_val(20),
               near_val(20), $urandom, 1);
    run_phase(80, 63, 0, 1'b0);

    if (answers_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, answers_due.size());
      errors++;
    end
    $display("covered %0d rays: %0d hits, %0d parallel, %0d behind, %0d errors",
             n_rays, n_hits, n_parallel, n_behind, errors);
    $display("over nine plane settings with idle, stall and long back-pressure phases");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### ray_plane_intersect.f
design/rpi_pkg.sv
design/rpi_front.sv
design/rpi_queue.sv
design/rpi_back.sv
design/rpi_out_fifo.sv
design/ray_plane_intersect.sv
bench/tb_top.sv
